// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker in snfu_checker.sv.
// Each macro wraps one clocked concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define SNFU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle.
`define SNFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/snfu_pkg.sv =====
// Package of the series and Newton function unit: codes, types, defaults.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps

package snfu_pkg;

  localparam int MAX_ITER_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_W         = 64;
  localparam int TOL_W         = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd7;

  localparam logic [1:0] ACT_SQRT = 2'd0;
  localparam logic [1:0] ACT_SIN  = 2'd1;
  localparam logic [1:0] ACT_EXP  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_NEG = 2'd1,
    ST_CAP = 2'd2,
    ST_SAT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_ACCEPT,
    CMD_MUL,
    CMD_DIV_LOAD,
    CMD_DIV_STEP,
    CMD_POST
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_DIV,
    S_POST,
    S_OUT
  } state_t;

  typedef struct packed {
    logic fin;
    logic is_sqrt;
    logic g_zero;
    logic div_last;
  } dp_status_t;

endpackage

// ===== hdl/snfu_datapath.sv =====
// Datapath: operand registers, shared multiplier, radix-2 divider, update logic.
// Depends on snfu_pkg; driven by snfu_ctrl commands.
`timescale 1ns / 1ps

module snfu_datapath #(
  parameter int MAX_ITERATIONS = snfu_pkg::MAX_ITER_DEF,
  parameter int FRACTION_BITS  = snfu_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  snfu_pkg::cmd_t              cmd,
  input  logic [1:0]                  in_action,
  input  logic signed [31:0]          in_operand,
  input  logic [snfu_pkg::TOL_W-1:0]  tolerance,
  output snfu_pkg::dp_status_t        stat,
  output logic signed [31:0]          out_value,
  output logic [1:0]                  out_status
);

  localparam int W   = snfu_pkg::DIV_W;
  localparam int KW  = $clog2(MAX_ITERATIONS + 1);
  localparam int CW  = $clog2(W);
  localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;
  localparam logic signed [W-1:0] VMAX = 64'sd2147483647;
  localparam logic signed [W-1:0] VMIN = -64'sd2147483648;

  logic [1:0]            act_r, act_nxt;
  logic                  xneg_r, xneg_nxt;
  logic [31:0]           xmag_r, xmag_nxt;
  logic                  tneg_r, tneg_nxt;
  logic [31:0]           tmag_r, tmag_nxt;
  logic [W-1:0]          g_r, g_nxt;
  logic signed [W-1:0]   acc_r, acc_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic                  phase_r, phase_nxt;
  logic [W-1:0]          num_r, num_nxt;
  logic [W-1:0]          den_r, den_nxt;
  logic [W-1:0]          rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  qneg_r, qneg_nxt;
  logic                  fin_r, fin_nxt;
  logic signed [W-1:0]   res_r, res_nxt;
  snfu_pkg::status_t     st_r, st_nxt;

  logic [31:0]           xin_mag;
  logic [W-1:0]          prod;
  logic [W-1:0]          remsh;
  logic signed [W-1:0]   tsig;
  logic signed [W-1:0]   accn;
  logic [W-1:0]          nx;
  logic [W-1:0]          dlt;
  logic [W-1:0]          tol_ext;
  logic [KW-1:0]         kn;
  logic                  is_sin;

  assign xin_mag = in_operand[31] ? (~in_operand + 32'd1) : in_operand;
  assign prod    = {32'b0, tmag_r} * {32'b0, xmag_r};
  assign remsh   = {rem_r[W-2:0], num_r[W-1]};
  assign tsig    = qneg_r ? -$signed(num_r) : $signed(num_r);
  assign accn    = acc_r + tsig;
  assign nx      = (g_r == '0) ? '0 : ((g_r + num_r) >> 1);
  assign dlt     = (nx >= g_r) ? (nx - g_r) : (g_r - nx);
  assign tol_ext = {{(W-snfu_pkg::TOL_W){1'b0}}, tolerance};
  assign kn      = k_r + KW'(1);
  assign is_sin  = (act_r == snfu_pkg::ACT_SIN);

  always_comb begin
    act_nxt   = act_r;
    xneg_nxt  = xneg_r;
    xmag_nxt  = xmag_r;
    tneg_nxt  = tneg_r;
    tmag_nxt  = tmag_r;
    g_nxt     = g_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    phase_nxt = phase_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    qneg_nxt  = qneg_r;
    fin_nxt   = fin_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    unique case (cmd)
      snfu_pkg::CMD_ACCEPT: begin
        act_nxt   = in_action;
        xneg_nxt  = in_operand[31];
        xmag_nxt  = xin_mag;
        fin_nxt   = 1'b0;
        res_nxt   = '0;
        st_nxt    = snfu_pkg::ST_OK;
        phase_nxt = 1'b0;
        g_nxt     = ({32'b0, xin_mag} + ONE) >> 1;
        k_nxt     = KW'(1);
        unique case (in_action)
          snfu_pkg::ACT_SQRT: begin
            k_nxt = '0;
            if (in_operand[31]) begin
              fin_nxt = 1'b1;
              st_nxt  = snfu_pkg::ST_NEG;
            end
          end
          snfu_pkg::ACT_SIN: begin
            acc_nxt  = W'(in_operand);
            tmag_nxt = xin_mag;
            tneg_nxt = in_operand[31];
          end
          snfu_pkg::ACT_EXP: begin
            acc_nxt  = $signed(ONE);
            tmag_nxt = ONE[31:0];
            tneg_nxt = 1'b0;
          end
          default: begin
            fin_nxt = 1'b1;
          end
        endcase
      end
      snfu_pkg::CMD_MUL: begin
        num_nxt  = prod >> FRACTION_BITS;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        qneg_nxt = tneg_r ^ xneg_r ^ (is_sin & phase_r);
        if (!is_sin) begin
          den_nxt = {{(W-KW){1'b0}}, k_r};
        end else begin
          den_nxt = {{(W-KW-1){1'b0}}, k_r, phase_r};
        end
      end
      snfu_pkg::CMD_DIV_LOAD: begin
        num_nxt = {32'b0, xmag_r} << FRACTION_BITS;
        den_nxt = g_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      snfu_pkg::CMD_DIV_STEP: begin
        cnt_nxt = cnt_r + CW'(1);
        if (remsh >= den_r) begin
          rem_nxt = remsh - den_r;
          num_nxt = {num_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = remsh;
          num_nxt = {num_r[W-2:0], 1'b0};
        end
      end
      snfu_pkg::CMD_POST: begin
        if (act_r == snfu_pkg::ACT_SQRT) begin
          g_nxt = nx;
          k_nxt = kn;
          res_nxt = $signed(nx);
          if (dlt <= tol_ext) begin
            fin_nxt = 1'b1;
            st_nxt  = snfu_pkg::ST_OK;
          end else if (kn == KW'(MAX_ITERATIONS)) begin
            fin_nxt = 1'b1;
            st_nxt  = snfu_pkg::ST_CAP;
          end
        end else if (num_r[W-1:32] != '0) begin
          fin_nxt = 1'b1;
          res_nxt = qneg_r ? VMIN : VMAX;
          st_nxt  = snfu_pkg::ST_SAT;
        end else if (is_sin && !phase_r) begin
          tmag_nxt  = num_r[31:0];
          tneg_nxt  = qneg_r;
          phase_nxt = 1'b1;
        end else begin
          acc_nxt   = accn;
          res_nxt   = accn;
          tmag_nxt  = num_r[31:0];
          tneg_nxt  = qneg_r;
          phase_nxt = 1'b0;
          if (num_r <= tol_ext) begin
            fin_nxt = 1'b1;
            st_nxt  = snfu_pkg::ST_OK;
          end else if (k_r == KW'(MAX_ITERATIONS)) begin
            fin_nxt = 1'b1;
            st_nxt  = snfu_pkg::ST_CAP;
          end else begin
            k_nxt = kn;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    xneg_r  <= xneg_nxt;
    xmag_r  <= xmag_nxt;
    tneg_r  <= tneg_nxt;
    tmag_r  <= tmag_nxt;
    g_r     <= g_nxt;
    acc_r   <= acc_nxt;
    k_r     <= k_nxt;
    phase_r <= phase_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    qneg_r  <= qneg_nxt;
    fin_r   <= fin_nxt;
    res_r   <= res_nxt;
    st_r    <= st_nxt;
  end

  assign stat.fin      = fin_r;
  assign stat.is_sqrt  = (act_r == snfu_pkg::ACT_SQRT);
  assign stat.g_zero   = (g_r == '0);
  assign stat.div_last = (cnt_r == '1);

  always_comb begin
    priority if (res_r > VMAX) begin
      out_value  = 32'sh7fffffff;
      out_status = snfu_pkg::ST_SAT;
    end else if (res_r < VMIN) begin
      out_value  = 32'sh80000000;
      out_status = snfu_pkg::ST_SAT;
    end else begin
      out_value  = res_r[31:0];
      out_status = st_r;
    end
  end

endmodule

// ===== hdl/snfu_ctrl.sv =====
// Controller: sequences accept, multiply, divide, update and result handoff.
// Depends on snfu_pkg; drives snfu_datapath commands.
`timescale 1ns / 1ps

module snfu_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  snfu_pkg::dp_status_t  stat,
  output snfu_pkg::cmd_t        cmd
);

  snfu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= snfu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = snfu_pkg::CMD_IDLE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      snfu_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd       = snfu_pkg::CMD_ACCEPT;
          state_nxt = snfu_pkg::S_LAUNCH;
        end
      end
      snfu_pkg::S_LAUNCH: begin
        priority if (stat.fin) begin
          state_nxt = snfu_pkg::S_OUT;
        end else if (stat.is_sqrt && stat.g_zero) begin
          state_nxt = snfu_pkg::S_POST;
        end else if (stat.is_sqrt) begin
          cmd       = snfu_pkg::CMD_DIV_LOAD;
          state_nxt = snfu_pkg::S_DIV;
        end else begin
          cmd       = snfu_pkg::CMD_MUL;
          state_nxt = snfu_pkg::S_DIV;
        end
      end
      snfu_pkg::S_DIV: begin
        cmd = snfu_pkg::CMD_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = snfu_pkg::S_POST;
        end
      end
      snfu_pkg::S_POST: begin
        cmd       = snfu_pkg::CMD_POST;
        state_nxt = snfu_pkg::S_LAUNCH;
      end
      snfu_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = snfu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = snfu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/series_and_newton_function_unit.sv =====
// Top level: one transaction at a time; out_valid rises once the last of p passes is done.
// Square root and e^x take one pass per iteration, sine two; p <= 2*MAX_ITERATIONS.
// A pass is one 64-step radix-2 divide plus load or multiply and update (no divide on a zero sqrt estimate).
// Throughput: next transaction accepted the cycle after the result is taken.
// Reset (rst_n, synchronous, active low) idles the controller, tolerance back to 7.
// Depends on snfu_pkg, snfu_ctrl and snfu_datapath.
`timescale 1ns / 1ps

module series_and_newton_function_unit #(
  parameter int MAX_ITERATIONS = snfu_pkg::MAX_ITER_DEF,
  parameter int FRACTION_BITS  = snfu_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic signed [31:0]          in_operand,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_value,
  output logic [1:0]                  out_status,
  input  logic                        cfg_wr_en,
  input  logic [snfu_pkg::TOL_W-1:0]  cfg_wr_data
);

  logic [snfu_pkg::TOL_W-1:0] tol_r;
  snfu_pkg::dp_status_t       stat;
  snfu_pkg::cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= snfu_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  snfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  snfu_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .in_action  (in_action),
    .in_operand (in_operand),
    .tolerance  (tol_r),
    .stat       (stat),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

// ===== hdl/snfu_checker.sv =====
// Port-level checker of the function unit, bound to the top level.
// Depends on snfu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module snfu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_value,
  input logic [1:0]         out_status
);

  `SNFU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_status))
  `SNFU_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && !in_stall, !out_valid)
  `SNFU_ASSERT_NOW(a_one_in_flight, clk, rst_n, out_valid, in_stall)
  `SNFU_ASSERT_NOW(a_neg_is_zero, clk, rst_n, out_valid && out_status == snfu_pkg::ST_NEG, out_value == 32'sd0)

endmodule

bind series_and_newton_function_unit snfu_checker u_chk (.*);
